// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define UTSID_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define UTSID_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/utsid_pkg.sv -----
// ----------------------------------------------------------------------------
// utsid_pkg
// Types, codes and field widths shared by the unsorted table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utsid_pkg;

    localparam int VALUE_W  = 16;
    localparam int CMD_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 4'd0,
        CMD_INSERT    = 4'd1,
        CMD_SEARCH    = 4'd2,
        CMD_DEL_ONE   = 4'd3,
        CMD_DEL_ALL   = 4'd4,
        CMD_CLEAR     = 4'd5,
        CMD_RST_CUR   = 4'd6,
        CMD_READ_NEXT = 4'd7,
        CMD_SPLIT     = 4'd8
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_PAST_END  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_DEL_WR,
        S_RN_EM,
        S_SPL_RD,
        S_SPL_EM
    } t_state;

    // Source of the result value
    typedef enum logic [1:0] {
        VS_ZERO,
        VS_ITEM,
        VS_RDATA
    } t_vsel;

    // Read address source
    typedef enum logic [1:0] {
        RA_PTR,
        RA_LAST,
        RA_CURSOR
    } t_rsel;

    // Write address and data source
    typedef enum logic {
        WA_COUNT,
        WA_CIDX
    } t_wsel;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    cur_clr;
        logic    cur_inc;
        logic    cur_to_cnt;
        logic    find_start;
        logic    find_restart;
        logic    find_step;
        logic    hit_set;
        logic    hit_clr;
        logic    out_load;
        t_vsel   out_vsel;
        logic    out_found;
        logic    out_side;
        t_status out_status;
        logic    out_last;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic hit;
        logic scan_done;
        logic split_last;
        logic cur_ok;
        logic out_free;
        logic any_hit;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/utsid_if.sv -----
// ----------------------------------------------------------------------------
// utsid channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface utsid_in_if import utsid_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] item_value;

    modport source (output valid, cmd, item_value, input ready);
    modport sink   (input valid, cmd, item_value, output ready);
endinterface

interface utsid_out_if import utsid_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  result_value;
    logic                found;
    logic                side;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic                is_empty;
    logic                last;

    modport source (output valid, result_value, found, side, status, count, is_full,
                    is_empty, last, input ready);
    modport sink   (input valid, result_value, found, side, status, count, is_full,
                    is_empty, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/unsorted_table_search_insert_delete.sv -----
// Append, clear, reset-cursor, unknown codes and a read past the end answer from the dispatch
// state; read-next of an entry reads the store first; search, insert and delete scan the table,
// delete-one then moving the last entry into the hole; split reads before its first word.
// One command at a time: the next word is taken only once the last result word has loaded,
// and output stalls hold the sequencer. Reset clears count, cursor and the result valid flag.
// ----------------------------------------------------------------------------
// unsorted_table_search_insert_delete
// Unordered table of up to CAPACITY values with linear search and swap delete.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_table_search_insert_delete import utsid_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utsid_in_if.sink    i_in,
    utsid_out_if.source o_out
);

    // Controller and datapath talk only through these two structs
    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;

    // The sequencer owns the input handshake; it takes a new word only
    // when the previous command has loaded its final result word.
    utsid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    // The datapath holds the entry RAM, count, cursor, scan pointer and the
    // output register, which lets a result wait while the next word arrives.
    utsid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_in.cmd),
        .i_item_value   (i_in.item_value),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_found        (o_out.found),
        .o_side         (o_out.side),
        .o_status       (o_out.status),
        .o_count        (o_out.count),
        .o_is_full      (o_out.is_full),
        .o_is_empty     (o_out.is_empty),
        .o_last         (o_out.last)
    );

endmodule

`default_nettype wire

// ----- rtl/utsid_ram.sv -----
// ----------------------------------------------------------------------------
// utsid_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module utsid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/utsid_datapath.sv -----
// ----------------------------------------------------------------------------
// utsid_datapath
// Entry store, count, read cursor, scan pointer and result word register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module utsid_datapath import utsid_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [VALUE_W-1:0]  i_item_value,
    input  t_dp_ctl             i_ctl,
    output t_dp_stat            o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [VALUE_W-1:0]  o_result_value,
    output logic                o_found,
    output logic                o_side,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_is_full,
    output logic                o_is_empty,
    output logic                o_last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Command word held for the whole operation
    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_item;

    logic [CW-1:0] r_count,  n_count;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_ptr,    n_ptr;
    logic [IW-1:0] r_cidx,   n_cidx;
    logic          r_pend,   n_pend;
    logic          r_hit,    n_hit;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_found;
    logic                r_out_side;
    logic [STATUS_W-1:0] r_out_status;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_full;
    logic                r_out_empty;
    logic                r_out_last;

    logic [IW-1:0]          w_rd_addr;
    logic [IW-1:0]          w_wr_addr;
    logic [VALUE_W-1:0]     w_wr_data;
    logic [VALUE_W-1:0]     w_rd_data;
    logic [CW-1:0]          w_cnt_m1;
    logic [CW+COUNT_W-1:0]  w_cnt_ext;
    logic                   w_out_free;
    logic [VALUE_W-1:0]     w_res_value;

    assign w_cnt_m1   = r_count - ONE_C;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_ctl.rd_sel)
            RA_PTR:    w_rd_addr = r_ptr[IW-1:0];
            RA_LAST:   w_rd_addr = w_cnt_m1[IW-1:0];
            RA_CURSOR: w_rd_addr = r_cursor[IW-1:0];
            default:   w_rd_addr = r_ptr[IW-1:0];
        endcase
    end

    // Append writes the new word at the end; a delete fills the hole with the last entry
    assign w_wr_addr = (i_ctl.wr_sel == WA_COUNT) ? r_count[IW-1:0] : r_cidx;
    assign w_wr_data = (i_ctl.wr_sel == WA_COUNT) ? r_item : w_rd_data;

    utsid_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        priority if (i_ctl.cnt_clr) begin
            n_count = '0;
        end else if (i_ctl.cnt_inc) begin
            n_count = r_count + ONE_C;
        end else if (i_ctl.cnt_dec) begin
            n_count = w_cnt_m1;
        end else begin
            n_count = r_count;
        end

        priority if (i_ctl.cur_clr) begin
            n_cursor = '0;
        end else if (i_ctl.cur_inc) begin
            n_cursor = r_cursor + ONE_C;
        end else if (i_ctl.cur_to_cnt) begin
            n_cursor = r_count;
        end else begin
            n_cursor = r_cursor;
        end

        n_ptr  = r_ptr;
        n_cidx = r_cidx;
        n_pend = r_pend;
        priority if (i_ctl.find_start) begin
            n_ptr  = '0;
            n_pend = 1'b0;
        end else if (i_ctl.find_restart) begin
            n_ptr  = CW'(r_cidx);
            n_pend = 1'b0;
        end else if (i_ctl.find_step) begin
            n_ptr  = r_ptr + ONE_C;
            n_cidx = r_ptr[IW-1:0];
            n_pend = 1'b1;
        end

        priority if (i_ctl.hit_clr) begin
            n_hit = 1'b0;
        end else if (i_ctl.hit_set) begin
            n_hit = 1'b1;
        end else begin
            n_hit = r_hit;
        end
    end

    always_comb begin
        unique case (i_ctl.out_vsel)
            VS_ZERO:  w_res_value = '0;
            VS_ITEM:  w_res_value = r_item;
            VS_RDATA: w_res_value = w_rd_data;
            default:  w_res_value = '0;
        endcase
    end

    assign w_cnt_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
            r_hit    <= n_hit;
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_cidx <= n_cidx;
        if (i_ctl.latch_in) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_item <= i_item_value;
        end
        if (i_ctl.out_load) begin
            r_out_value  <= w_res_value;
            r_out_found  <= i_ctl.out_found;
            r_out_side   <= i_ctl.out_side && (w_rd_data >= r_item);
            r_out_status <= i_ctl.out_status;
            r_out_count  <= w_cnt_ext[COUNT_W-1:0];
            r_out_full   <= (n_count == CAP_C);
            r_out_empty  <= (n_count == '0);
            r_out_last   <= i_ctl.out_last;
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.full       = (r_count == CAP_C);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.hit        = r_pend && (w_rd_data == r_item);
    assign o_stat.scan_done  = (r_ptr >= r_count);
    assign o_stat.split_last = (CW'(r_cidx) == w_cnt_m1);
    assign o_stat.cur_ok     = (r_cursor < r_count);
    assign o_stat.out_free   = w_out_free;
    assign o_stat.any_hit    = r_hit;

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_found        = r_out_found;
    assign o_side         = r_out_side;
    assign o_status       = r_out_status;
    assign o_count        = r_out_count;
    assign o_is_full      = r_out_full;
    assign o_is_empty     = r_out_empty;
    assign o_last         = r_out_last;

    `UTSID_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "entry count above capacity")
    `UTSID_ASSERT_IMPL(a_append_room, i_clk, i_rst_n, i_ctl.wr_en && (i_ctl.wr_sel == WA_COUNT), r_count < CAP_C, "append into a full table")
    `UTSID_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, i_ctl.out_load, w_out_free, "result word overwritten before it was taken")
    `UTSID_ASSERT_IMPL(a_dec_nonzero, i_clk, i_rst_n, i_ctl.cnt_dec, r_count != '0, "delete from an empty table")

endmodule

`default_nettype wire

// ----- rtl/utsid_ctrl.sv -----
// ----------------------------------------------------------------------------
// utsid_ctrl
// Command sequencer: dispatch, linear scan, swap delete, cursor read, split.
// ----------------------------------------------------------------------------
`default_nettype none

module utsid_ctrl import utsid_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_INSERT, CMD_SEARCH, CMD_DEL_ONE, CMD_DEL_ALL: begin
                        n_state = S_FIND;
                    end
                    CMD_READ_NEXT: begin
                        if (i_stat.cur_ok) begin
                            n_state = S_RN_EM;
                        end else if (i_stat.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_SPLIT: begin
                        if (!i_stat.empty) begin
                            n_state = S_SPL_RD;
                        end else if (i_stat.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_FIND: begin
                if (i_stat.hit) begin
                    if (i_stat.cmd == CMD_DEL_ONE || i_stat.cmd == CMD_DEL_ALL) begin
                        n_state = S_DEL_WR;
                    end else if (i_stat.out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.scan_done && i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL_WR: begin
                if (i_stat.cmd == CMD_DEL_ALL) begin
                    n_state = S_FIND;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RN_EM: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SPL_RD: begin
                n_state = S_SPL_EM;
            end
            S_SPL_EM: begin
                if (i_stat.out_free && i_stat.split_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctl.latch_in = i_in_valid;
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_APPEND: begin
                        if (i_stat.out_free) begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_ctl.out_status = ST_FULL;
                            end else begin
                                o_ctl.wr_en   = 1'b1;
                                o_ctl.wr_sel  = WA_COUNT;
                                o_ctl.cnt_inc = 1'b1;
                            end
                        end
                    end
                    CMD_INSERT, CMD_SEARCH, CMD_DEL_ONE, CMD_DEL_ALL: begin
                        o_ctl.find_start = 1'b1;
                        o_ctl.hit_clr    = 1'b1;
                    end
                    CMD_CLEAR: begin
                        if (i_stat.out_free) begin
                            o_ctl.cnt_clr  = 1'b1;
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                        end
                    end
                    CMD_RST_CUR: begin
                        if (i_stat.out_free) begin
                            o_ctl.cur_clr  = 1'b1;
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                        end
                    end
                    CMD_READ_NEXT: begin
                        if (i_stat.cur_ok) begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = RA_CURSOR;
                        end else if (i_stat.out_free) begin
                            o_ctl.out_load   = 1'b1;
                            o_ctl.out_status = ST_PAST_END;
                            o_ctl.out_last   = 1'b1;
                        end
                    end
                    CMD_SPLIT: begin
                        if (!i_stat.empty) begin
                            o_ctl.find_start = 1'b1;
                        end else if (i_stat.out_free) begin
                            o_ctl.cur_to_cnt = 1'b1;
                            o_ctl.out_load   = 1'b1;
                            o_ctl.out_last   = 1'b1;
                        end
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                        end
                    end
                endcase
            end
            S_FIND: begin
                if (i_stat.hit) begin
                    if (i_stat.cmd == CMD_DEL_ONE || i_stat.cmd == CMD_DEL_ALL) begin
                        // fetch the last entry to fill the hole
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.rd_sel = RA_LAST;
                    end else if (i_stat.out_free) begin
                        o_ctl.out_load  = 1'b1;
                        o_ctl.out_found = 1'b1;
                        o_ctl.out_vsel  = VS_ITEM;
                        o_ctl.out_last  = 1'b1;
                    end
                end else if (i_stat.scan_done) begin
                    if (i_stat.out_free) begin
                        o_ctl.out_load = 1'b1;
                        o_ctl.out_last = 1'b1;
                        unique case (i_stat.cmd)
                            CMD_INSERT: begin
                                if (i_stat.full) begin
                                    o_ctl.out_status = ST_FULL;
                                end else begin
                                    o_ctl.wr_en   = 1'b1;
                                    o_ctl.wr_sel  = WA_COUNT;
                                    o_ctl.cnt_inc = 1'b1;
                                end
                            end
                            CMD_DEL_ALL: begin
                                o_ctl.cur_to_cnt = 1'b1;
                                if (i_stat.any_hit) begin
                                    o_ctl.out_found = 1'b1;
                                    o_ctl.out_vsel  = VS_ITEM;
                                end else begin
                                    o_ctl.out_status = ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                o_ctl.out_status = ST_NOT_FOUND;
                            end
                        endcase
                    end
                end else begin
                    o_ctl.find_step = 1'b1;
                    o_ctl.rd_en     = 1'b1;
                    o_ctl.rd_sel    = RA_PTR;
                end
            end
            S_DEL_WR: begin
                if (i_stat.cmd == CMD_DEL_ALL) begin
                    // the moved entry lands in the hole: examine that slot again
                    o_ctl.wr_en        = 1'b1;
                    o_ctl.wr_sel       = WA_CIDX;
                    o_ctl.cnt_dec      = 1'b1;
                    o_ctl.hit_set      = 1'b1;
                    o_ctl.find_restart = 1'b1;
                end else if (i_stat.out_free) begin
                    o_ctl.wr_en     = 1'b1;
                    o_ctl.wr_sel    = WA_CIDX;
                    o_ctl.cnt_dec   = 1'b1;
                    o_ctl.out_load  = 1'b1;
                    o_ctl.out_found = 1'b1;
                    o_ctl.out_vsel  = VS_ITEM;
                    o_ctl.out_last  = 1'b1;
                end
            end
            S_RN_EM: begin
                if (i_stat.out_free) begin
                    o_ctl.cur_inc  = 1'b1;
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_vsel = VS_RDATA;
                    o_ctl.out_last = 1'b1;
                end
            end
            S_SPL_RD: begin
                o_ctl.find_step = 1'b1;
                o_ctl.rd_en     = 1'b1;
                o_ctl.rd_sel    = RA_PTR;
            end
            S_SPL_EM: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_vsel = VS_RDATA;
                    o_ctl.out_side = 1'b1;
                    o_ctl.out_last = i_stat.split_last;
                    if (i_stat.split_last) begin
                        o_ctl.cur_to_cnt = 1'b1;
                    end else begin
                        o_ctl.find_step = 1'b1;
                        o_ctl.rd_en     = 1'b1;
                        o_ctl.rd_sel    = RA_PTR;
                    end
                end
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sim/tb_unsorted_table_search_insert_delete.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unsorted_table_search_insert_delete
// Self-checking bench for the unsorted table. A driver feeds command words from
// a backlog and a monitor checks every result word against a behavioural mirror
// of the table, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_unsorted_table_search_insert_delete;
    import utsid_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int TOTAL_WORDS = 520;
    localparam int IDLE_PCT    = 17;

    // Command codes the block does not decode; they must answer with a plain ok.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        bit                 drain_first;  // hold this word until nothing is awaited
    } t_cmd_word;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               found;
        logic               side;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               is_full;
        logic               is_empty;
        logic               last;
    } t_result_word;

    logic i_clk;
    logic i_rst_n;

    utsid_in_if  cmd_ch ();
    utsid_out_if res_ch ();

    unsorted_table_search_insert_delete #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    // ------------------------------------------------------------------------
    // Mirror of the table and the queues around it
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] table_mirror [TABLE_DEPTH];
    int                 mirror_count;
    int                 mirror_cursor;
    int                 peak_count;

    t_cmd_word    command_backlog [$];
    t_result_word awaited_results [$];

    int   words_sent;
    int   results_checked;
    int   refused_words;
    int   errors;
    logic calm_stretch;

    // A long stretch with neither side idling, part way through the random part
    assign calm_stretch = (words_sent >= 200) && (words_sent < 320);

    // Queue one expected result word, stamped with the mirror's current flags.
    function automatic void await_result(input logic [VALUE_W-1:0] v, input logic fnd,
                                         input logic sd, input t_status st,
                                         input logic lst);
        t_result_word w;
        w.value    = v;
        w.found    = fnd;
        w.side     = sd;
        w.status   = st;
        w.count    = COUNT_W'(mirror_count);
        w.is_full  = (mirror_count == TABLE_DEPTH);
        w.is_empty = (mirror_count == 0);
        w.last     = lst;
        if (st != ST_OK)
            refused_words++;
        awaited_results.push_back(w);
    endfunction

    // Advance the mirror by one accepted command word and queue what it yields.
    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] v);
        int                 first_hit;
        int                 i;
        logic               hit;
        logic [VALUE_W-1:0] e;
        // Scan downwards so the lowest matching slot wins; misses leave it at count
        first_hit = mirror_count;
        for (i = mirror_count - 1; i >= 0; i--)
            if (table_mirror[i] == v)
                first_hit = i;
        case (cmd)
            CMD_APPEND: begin
                if (mirror_count >= TABLE_DEPTH) begin
                    await_result('0, 1'b0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    table_mirror[mirror_count] = v;
                    mirror_count++;
                    await_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            CMD_INSERT: begin
                if (first_hit < mirror_count) begin
                    await_result(table_mirror[first_hit], 1'b1, 1'b0, ST_OK, 1'b1);
                end else if (mirror_count >= TABLE_DEPTH) begin
                    await_result('0, 1'b0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    table_mirror[mirror_count] = v;
                    mirror_count++;
                    await_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            CMD_SEARCH: begin
                if (first_hit < mirror_count)
                    await_result(table_mirror[first_hit], 1'b1, 1'b0, ST_OK, 1'b1);
                else
                    await_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
            end
            CMD_DEL_ONE: begin
                if (first_hit < mirror_count) begin
                    // Move the last entry into the freed slot
                    e = table_mirror[first_hit];
                    table_mirror[first_hit] = table_mirror[mirror_count - 1];
                    mirror_count--;
                    await_result(e, 1'b1, 1'b0, ST_OK, 1'b1);
                end else begin
                    await_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
                end
            end
            CMD_DEL_ALL: begin
                // A slot that just took the last entry is examined again
                hit = 1'b0;
                i   = 0;
                while (i < mirror_count) begin
                    if (table_mirror[i] == v) begin
                        table_mirror[i] = table_mirror[mirror_count - 1];
                        mirror_count--;
                        hit = 1'b1;
                    end else begin
                        i++;
                    end
                end
                mirror_cursor = mirror_count;
                if (hit)
                    await_result(v, 1'b1, 1'b0, ST_OK, 1'b1);
                else
                    await_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
            end
            CMD_CLEAR: begin
                // The read cursor is deliberately left where it was
                mirror_count = 0;
                await_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
            end
            CMD_RST_CUR: begin
                mirror_cursor = 0;
                await_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
            end
            CMD_READ_NEXT: begin
                if (mirror_cursor < mirror_count) begin
                    e = table_mirror[mirror_cursor];
                    mirror_cursor++;
                    await_result(e, 1'b0, 1'b0, ST_OK, 1'b1);
                end else begin
                    await_result('0, 1'b0, 1'b0, ST_PAST_END, 1'b1);
                end
            end
            CMD_SPLIT: begin
                // One word per stored entry in table order; an empty table gives one
                // blank word
                mirror_cursor = mirror_count;
                if (mirror_count == 0) begin
                    await_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end else begin
                    for (i = 0; i < mirror_count; i++)
                        await_result(table_mirror[i], 1'b0, table_mirror[i] >= v, ST_OK,
                                     i == mirror_count - 1);
                end
            end
            default: begin
                await_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
            end
        endcase
        if (mirror_count > peak_count)
            peak_count = mirror_count;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] key_pool [8];

    function automatic void enqueue_command(input logic [CMD_W-1:0] cmd,
                                            input logic [VALUE_W-1:0] v,
                                            input bit drain = 1'b0);
        t_cmd_word w;
        w.cmd         = cmd;
        w.value       = v;
        w.drain_first = drain;
        command_backlog.push_back(w);
    endfunction

    // Mostly reuse a small set of keys so that searches and deletes hit often.
    function automatic logic [VALUE_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 75)
            return key_pool[$urandom_range(0, 7)];
        return VALUE_W'($urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present backlog words, predict each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : cmd_driver
        t_cmd_word nxt;
        bit        slot_free;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            slot_free = !cmd_ch.valid || cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready) begin
                apply_command(cmd_ch.cmd, cmd_ch.item_value);
                words_sent++;
            end
            if (slot_free) begin
                // Hold a drain word back until every awaited result has arrived
                if (command_backlog.size() > 0
                    && !(command_backlog[0].drain_first && awaited_results.size() > 0)
                    && (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = command_backlog.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.cmd        <= nxt.cmd;
                    cmd_ch.item_value <= nxt.value;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall at random, check every accepted result word in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result_word want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_checked++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result word: value=%h status=%0d count=%0d last=%b",
                             $time, res_ch.result_value, res_ch.status, res_ch.count,
                             res_ch.last);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.value !== res_ch.result_value || want.found !== res_ch.found
                        || want.side !== res_ch.side || want.status !== res_ch.status
                        || want.count !== res_ch.count || want.is_full !== res_ch.is_full
                        || want.is_empty !== res_ch.is_empty || want.last !== res_ch.last) begin
                        $display("%0t: mismatch: expected value=%h found=%b side=%b status=%0d count=%0d full=%b empty=%b last=%b",
                                 $time, want.value, want.found, want.side, want.status,
                                 want.count, want.is_full, want.is_empty, want.last);
                        $display("%0t:           actual value=%h found=%b side=%b status=%0d count=%0d full=%b empty=%b last=%b",
                                 $time, res_ch.result_value, res_ch.found, res_ch.side,
                                 res_ch.status, res_ch.count, res_ch.is_full,
                                 res_ch.is_empty, res_ch.last);
                        errors++;
                    end
                end
            end
            res_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------------
    initial begin
        #1000000;
        $display("tb_unsorted_table_search_insert_delete failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int               episode;
        int               n;
        int               k;
        int               r;
        logic [CMD_W-1:0] c;

        // Drive every input to a known value from time zero
        i_rst_n           = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = '0;
        cmd_ch.item_value = '0;
        res_ch.ready      = 1'b0;
        mirror_count      = 0;
        mirror_cursor     = 0;
        peak_count        = 0;
        words_sent        = 0;
        results_checked   = 0;
        refused_words     = 0;
        errors            = 0;
        for (k = 0; k < TABLE_DEPTH; k++)
            table_mirror[k] = '0;

        // Directed part: empty-table corner cases first
        enqueue_command(CMD_SPLIT, 16'h4000);      // split of an empty table
        enqueue_command(CMD_READ_NEXT, 16'h0000);  // read past the end
        enqueue_command(CMD_SEARCH, 16'h0000);     // search miss
        enqueue_command(CMD_DEL_ONE, 16'hFFFF);    // delete with nothing to find
        enqueue_command(CMD_DEL_ALL, 16'h0000);
        // Build [1234 FFFF 0000 1234 00FF 1234] with a duplicate insert on the way
        enqueue_command(CMD_APPEND, 16'h1234);
        enqueue_command(CMD_APPEND, 16'hFFFF);
        enqueue_command(CMD_APPEND, 16'h0000);
        enqueue_command(CMD_APPEND, 16'h1234);
        enqueue_command(CMD_INSERT, 16'h1234);     // already present
        enqueue_command(CMD_INSERT, 16'h00FF);     // absent, goes in
        enqueue_command(CMD_APPEND, 16'h1234);
        enqueue_command(CMD_SEARCH, 16'hFFFF);
        enqueue_command(CMD_RST_CUR, 16'h0000);
        enqueue_command(CMD_READ_NEXT, 16'h0000);
        enqueue_command(CMD_READ_NEXT, 16'h0000);
        enqueue_command(CMD_SPLIT, 16'h1234);
        // Delete-all pulls a matching last entry into a matching slot
        enqueue_command(CMD_DEL_ALL, 16'h1234);
        enqueue_command(CMD_DEL_ONE, 16'hFFFF);
        enqueue_command(CMD_READ_NEXT, 16'h0000);  // cursor parked past the count
        enqueue_command(CMD_UNUSED_LO, 16'hA5A5);
        enqueue_command(CMD_UNUSED_HI, 16'hFFFF);
        enqueue_command(CMD_CLEAR, 16'h0000, 1'b1);
        enqueue_command(CMD_READ_NEXT, 16'h0000);  // cursor beyond a cleared table

        // Random part, built from episodes of related commands
        while (command_backlog.size() < TOTAL_WORDS) begin
            if ($urandom_range(0, 3) == 0) begin
                for (k = 0; k < 8; k++)
                    key_pool[k] = VALUE_W'($urandom_range(0, 65535));
                key_pool[0] = '0;
                key_pool[1] = '1;
            end
            episode = $urandom_range(0, 9);
            if (episode <= 1) begin
                // Fill to capacity and beyond, then try an insert on a full table
                if ($urandom_range(0, 1))
                    enqueue_command(CMD_CLEAR, pick_key());
                n = $urandom_range(28, 36);
                for (k = 0; k < n; k++)
                    enqueue_command(($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_APPEND,
                                    pick_key());
                enqueue_command(CMD_INSERT, VALUE_W'($urandom_range(0, 65535)));
                enqueue_command(CMD_SPLIT, pick_key());
            end else if (episode <= 6) begin
                n = $urandom_range(10, 20);
                for (k = 0; k < n; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 22)      c = CMD_APPEND;
                    else if (r < 32) c = CMD_INSERT;
                    else if (r < 47) c = CMD_SEARCH;
                    else if (r < 58) c = CMD_DEL_ONE;
                    else if (r < 64) c = CMD_DEL_ALL;
                    else if (r < 78) c = CMD_READ_NEXT;
                    else if (r < 84) c = CMD_RST_CUR;
                    else if (r < 90) c = CMD_SPLIT;
                    else if (r < 93) c = CMD_CLEAR;
                    else             c = CMD_W'($urandom_range(9, 15));
                    enqueue_command(c, pick_key());
                end
            end else if (episode == 7) begin
                // Walk the cursor through the table and off its end
                enqueue_command(CMD_RST_CUR, pick_key());
                n = $urandom_range(3, 34);
                for (k = 0; k < n; k++)
                    enqueue_command(CMD_READ_NEXT, VALUE_W'($urandom_range(0, 65535)));
            end else if (episode == 8) begin
                // Noise: any code, any value
                n = $urandom_range(5, 10);
                for (k = 0; k < n; k++)
                    enqueue_command(CMD_W'($urandom_range(0, 15)),
                                    VALUE_W'($urandom_range(0, 65535)));
            end else begin
                // Let the block drain completely before carrying on
                enqueue_command(CMD_SEARCH, pick_key(), 1'b1);
                enqueue_command(CMD_SPLIT, pick_key());
            end
        end

        // Synchronous reset, then release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the backlog to be taken, then for every awaited word
        while (command_backlog.size() > 0 || cmd_ch.valid)
            @(posedge i_clk);
        while (awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d command words and checked %0d result words (%0d refused).",
                 words_sent, results_checked, refused_words);
        $display("Table occupancy reached %0d of %0d entries.", peak_count, TABLE_DEPTH);
        if (errors == 0)
            $display("tb_unsorted_table_search_insert_delete passed");
        else
            $display("tb_unsorted_table_search_insert_delete failed");
        $finish;
    end

endmodule
